/* rtl/wbps_pkg.sv */
// Shared types and constants for the wildcard byte pattern search.
// No dependencies; imported by wbps_cell and the top level.
`default_nettype none

package wbps_pkg;

    localparam int BYTE_W          = 8;
    localparam int PATTERN_MAX_DEF = 16;

    // Per-beat controls broadcast from the top level to every window cell.
    typedef struct packed {
        logic shift;   // take the neighbor's byte
        logic clear;   // end of image: empty the window
    } cell_ctrl_t;

endpackage : wbps_pkg

`default_nettype wire

/* rtl/wildcard_byte_pattern_search.sv */
// Top level of the wildcard byte pattern search: window cell chain, counters,
// configuration registers and result register. Depends on wbps_pkg, wbps_cell.
//
//  channel   dir  beat contents                      handshake
//  -------   ---  ---------------------------------  ----------------------
//  s_axis    in   tdata = image_byte, tlast = last   tvalid / tready
//  m_axis    out  tdata = match_offset, tuser = found tvalid / tready
//  cfg       in   cfg_index, cfg_data                cfg_we, no stall
//
// One image byte per cycle while ready: the whole signature compare is one
// rank of per-cell byte comparators feeding an AND, done in the cycle the
// byte is taken, with the result landing in the output register next edge.
// The single output register lets a new byte in whenever it is empty or is
// being drained in the same cycle; a stalled result holds only the input.
// Reset empties the window, the byte count and the match flag at once, and
// loads the configuration defaults (length 1, everything else zero).
`default_nettype none

module wildcard_byte_pattern_search #(
    parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // input stream
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [7:0]                   s_axis_tdata,   // [7:0] image_byte
    input  wire logic                         s_axis_tlast,   // last_byte
    // result stream
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic      [31:0]                  m_axis_tdata,   // [31:0] match_offset
    output logic                              m_axis_tuser,   // [0] found
    // configuration writes
    input  wire logic                         cfg_we,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [63:0]                  cfg_data
);
    import wbps_pkg::*;

    localparam int LEN_W     = $clog2(PATTERN_MAX + 1);
    localparam int SIG_IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int SIG_W     = BYTE_W * PATTERN_MAX;

    // register indexes
    localparam logic [1:0] CFG_PAT_LO = 2'd0;
    localparam logic [1:0] CFG_PAT_HI = 2'd1;
    localparam logic [1:0] CFG_WILD   = 2'd2;
    localparam logic [1:0] CFG_LEN    = 2'd3;

    // ---------------- configuration registers ----------------
    logic [63:0] pat_lo_reg;
    logic [63:0] pat_hi_reg;
    logic [15:0] wild_reg;
    logic [4:0]  len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
            wild_reg   <= '0;
            len_reg    <= 5'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PAT_LO: pat_lo_reg <= cfg_data;
                CFG_PAT_HI: pat_hi_reg <= cfg_data;
                CFG_WILD:   wild_reg   <= cfg_data[15:0];
                CFG_LEN:    len_reg    <= cfg_data[4:0];
            endcase
        end
    end

    // Length clamped to 1..PATTERN_MAX.
    logic [LEN_W-1:0] len_eff;
    always_comb
    begin
        priority if (len_reg == 5'd0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (len_reg > 5'(PATTERN_MAX))
        begin
            len_eff = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            len_eff = len_reg[LEN_W-1:0];
        end
    end

    logic [127:0]           sig_all;
    logic [SIG_W-1:0]       sig_vec;
    logic [PATTERN_MAX-1:0] wild_vec;
    assign sig_all  = {pat_hi_reg, pat_lo_reg};
    assign sig_vec  = sig_all[SIG_W-1:0];
    assign wild_vec = wild_reg[PATTERN_MAX-1:0];

    // ---------------- handshake and beat controls ----------------
    logic       out_valid_reg;
    logic       found_reg;
    logic [31:0] offset_reg;
    logic       reported_reg;
    logic [31:0] seen_reg;

    logic       in_beat;
    cell_ctrl_t cell_ctrl;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // after a match the window freezes until the last byte
    assign cell_ctrl.shift = in_beat && !reported_reg;
    assign cell_ctrl.clear = in_beat && s_axis_tlast;

    // ---------------- window cell chain ----------------
    // cell 0 holds the newest byte; cell k is compared with signature byte
    // len-1-k, cells at or beyond the length always hit
    logic [BYTE_W-1:0]      chain   [PATTERN_MAX+1];
    logic [PATTERN_MAX-1:0] hit_vec;

    assign chain[0] = s_axis_tdata;

    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        logic                 active;
        logic [LEN_W-1:0]     idx_full;
        logic [SIG_IDX_W-1:0] idx;
        logic [BYTE_W-1:0]    sig_byte;
        logic                 wild;

        assign active   = LEN_W'(k) < len_eff;
        assign idx_full = len_eff - LEN_W'(k + 1);
        assign idx      = idx_full[SIG_IDX_W-1:0];
        assign sig_byte = sig_vec[BYTE_W*idx +: BYTE_W];
        assign wild     = !active || wild_vec[idx];

        wbps_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .byte_in  (chain[k]),
            .sig_byte (sig_byte),
            .wild     (wild),
            .byte_out (chain[k+1]),
            .hit      (hit_vec[k])
        );
    end

    // ---------------- byte count and match decision ----------------
    logic [31:0] seen_next;
    logic        enough;
    logic        match_now;
    logic        emit;
    logic [31:0] offset_now;

    assign seen_next  = (seen_reg == '1) ? seen_reg : seen_reg + 32'd1;  // saturates
    assign enough     = seen_next >= 32'(len_eff);
    assign match_now  = !reported_reg && enough && (&hit_vec);
    // no match yet: either report it now or, on the last byte, report a miss
    assign emit       = !reported_reg && (match_now || s_axis_tlast);
    assign offset_now = match_now ? (seen_next - 32'(len_eff)) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= '0;
            reported_reg <= 1'b0;
        end
        else if (in_beat)
        begin
            if (s_axis_tlast)
            begin
                seen_reg     <= '0;
                reported_reg <= 1'b0;
            end
            else if (!reported_reg)
            begin
                seen_reg     <= seen_next;
                reported_reg <= match_now;
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_beat && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat && emit)
        begin
            found_reg  <= match_now;
            offset_reg <= offset_now;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = offset_reg;
    assign m_axis_tuser  = found_reg;

endmodule : wildcard_byte_pattern_search

`default_nettype wire

/* rtl/wbps_cell.sv */
// One window cell: holds one recent image byte and compares the byte it is
// about to take against its signature byte. Depends on wbps_pkg.
`default_nettype none

module wbps_cell (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire wbps_pkg::cell_ctrl_t         ctrl,
    input  wire logic [wbps_pkg::BYTE_W-1:0]  byte_in,
    input  wire logic [wbps_pkg::BYTE_W-1:0]  sig_byte,
    input  wire logic                         wild,
    output logic      [wbps_pkg::BYTE_W-1:0]  byte_out,
    output logic                              hit
);
    import wbps_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    // compare on the incoming byte: it is what this cell holds after the shift
    assign hit = wild || (byte_in == sig_byte);

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.clear)
        begin
            byte_next = '0;
        end
        else if (ctrl.shift)
        begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

endmodule : wbps_cell

`default_nettype wire

/* rtl/wbps_checker.sv */
// Port-level checks for the wildcard byte pattern search, bound to the top.
// Depends only on the top level's ports.
`default_nettype none

module wbps_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

    // a miss always reports offset zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 32'd0)
        else $error("not-found result with nonzero offset");

    // the input never stalls while the result register is empty
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // no result appears without an input beat before it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid && !(s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("result appeared without an input beat");

    // a non-last byte taken into an empty result register never yields a miss;
    // a last byte yields a result unless its image already reported a match
    a_miss_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid && s_axis_tvalid && s_axis_tready && !s_axis_tlast
            |=> !(m_axis_tvalid && !m_axis_tuser))
        else $error("not-found result without a last byte");

endmodule : wbps_checker

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
